// ----- hw/rtl/alts_pkg.sv -----
// Shared types, codes and constants of the audio level ranking block.
// No dependencies; every other file but alts_div uses these by scoped name.
package alts_pkg;

   localparam int MAX_SOURCES_DEF = 16;
   localparam int MIN_SAMPLES_DEF = 10;
   localparam int RESULT_CAP      = 16;
   localparam logic [12:0] IVL_MIN = 13'd250;
   localparam logic [12:0] IVL_MAX = 13'd5000;

   localparam logic [2:0] KIND_SAMPLE = 3'd0;
   localparam logic [2:0] KIND_TICK   = 3'd1;
   localparam logic [2:0] KIND_ATTACH = 3'd2;
   localparam logic [2:0] KIND_DETACH = 3'd3;
   localparam logic [2:0] KIND_PAUSE  = 3'd4;
   localparam logic [2:0] KIND_RESUME = 3'd5;

   localparam logic [1:0] CSR_MAX_ENTRIES = 2'd0;
   localparam logic [1:0] CSR_THRESHOLD   = 2'd1;
   localparam logic [1:0] CSR_INTERVAL    = 2'd2;

   localparam logic EV_VOLUME  = 1'b0;
   localparam logic EV_SILENCE = 1'b1;

   typedef struct packed {
      logic [2:0] kind;
      logic [3:0] source_slot;
      logic [6:0] audio_level;
   } req_type;

   typedef struct packed {
      logic              event_res;
      logic [3:0]        speaker_slot;
      logic signed [7:0] average_dbov;
      logic              last_of_run;
   } rsp_type;

   typedef struct packed {
      logic [15:0] level_sum;
      logic [15:0] sample_count;
   } stats_type;

   typedef struct packed {
      logic rd_en;
      logic wr_en;
      logic clr_one;
      logic clr_all;
   } tbl_cmd_type;

endpackage

// ----- hw/rtl/alts_div.sv -----
// Serial restoring divider of 16-bit operands, one quotient bit per cycle.
// Depends on nothing but the clock and reset.
module alts_div (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   input  logic [15:0] dividend,
   input  logic [15:0] divisor,
   output logic        done,
   output logic [15:0] quotient
);

   logic [15:0] rem_ff, rem_in;
   logic [15:0] quo_ff, quo_in;
   logic [15:0] dvs_ff, dvs_in;
   logic [4:0]  cnt_ff, cnt_in;
   logic        busy_ff, busy_in;
   logic        done_ff, done_in;
   logic [16:0] trial;

   always_comb begin
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      dvs_in  = dvs_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      trial   = {rem_ff, quo_ff[15]};
      if (start) begin
         rem_in  = '0;
         quo_in  = dividend;
         dvs_in  = divisor;
         cnt_in  = 5'd0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if (trial >= {1'b0, dvs_ff}) begin
            rem_in = 16'(trial - {1'b0, dvs_ff});
            quo_in = {quo_ff[14:0], 1'b1};
         end else begin
            rem_in = trial[15:0];
            quo_in = {quo_ff[14:0], 1'b0};
         end
         cnt_in = cnt_ff + 5'd1;
         if (cnt_ff == 5'd15) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      dvs_ff <= dvs_in;
      cnt_ff <= cnt_in;
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   assign done     = done_ff;
   assign quotient = quo_ff;

endmodule

// ----- hw/rtl/alts_table.sv -----
// Per-source sum and count memory, registered read, with fresh bits.
// Depends on alts_pkg for the entry and command types.
module alts_table #(
   parameter int MAX_SOURCES = alts_pkg::MAX_SOURCES_DEF
) (
   input  logic                           clock,
   input  logic                           reset,
   input  alts_pkg::tbl_cmd_type          cmd,
   input  logic [$clog2(MAX_SOURCES)-1:0] addr,
   input  alts_pkg::stats_type            wr_data,
   output alts_pkg::stats_type            rd_data
);

   alts_pkg::stats_type          mem [MAX_SOURCES];
   alts_pkg::stats_type          rd_q_ff;
   logic [MAX_SOURCES-1:0]       fresh_ff;
   logic                         rd_fresh_ff;

   always_ff @(posedge clock) begin
      if (cmd.wr_en) begin
         mem[addr] <= wr_data;
      end
      if (cmd.rd_en) begin
         rd_q_ff <= mem[addr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fresh_ff    <= '0;
         rd_fresh_ff <= 1'b0;
      end else begin
         if (cmd.rd_en) begin
            rd_fresh_ff <= fresh_ff[addr];
         end
         if (cmd.clr_all) begin
            fresh_ff <= '0;
         end else if (cmd.clr_one) begin
            fresh_ff[addr] <= 1'b0;
         end else if (cmd.wr_en) begin
            fresh_ff[addr] <= 1'b1;
         end
      end
   end

   assign rd_data = rd_fresh_ff ? rd_q_ff : '0;

endmodule

// ----- hw/rtl/audio_level_top_speakers.sv -----
// Audio level ranking block: top level with sequencer, average memory and result register.
// Depends on alts_pkg, alts_table and alts_div.
//
// Use: req_ carries one beat per event (level sample, millisecond tick, attach,
// detach, pause, resume); rsp_ returns volume entries loudest first and silence
// notices, the final beat of a run marked by last_of_run. csr_ writes the entry
// limit, threshold and interval; csr_ready is always high.
// Flow: a sample is a table read, then a write back; other events are handled in the
// cycle they are taken, but a pause while not silent also emits a silence notice. A tick
// that closes the interval runs an update: each slot is read and, if it is active with
// enough samples, divided in the serial divider; each emitted entry then takes a ranking
// pass over the average memory. req_stall is high while any event is in progress, so one
// event is handled at a time.
// A result waits in an output register; a stalled rsp_ beat holds and further
// results wait, while events that give no result are still taken.
// Reset: table empty, timer at zero, not paused, silence flagged,
// registers at limit 1, threshold -80, interval 1000. No clearing pass is needed.
module audio_level_top_speakers #(
   parameter int MAX_SOURCES = alts_pkg::MAX_SOURCES_DEF,
   parameter int MIN_SAMPLES = alts_pkg::MIN_SAMPLES_DEF
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  alts_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output alts_pkg::rsp_type rsp_data,
   input  logic              csr_valid,
   output logic              csr_ready,
   input  logic [1:0]        csr_index,
   input  logic [12:0]       csr_wdata
);

   localparam int IDX_W = $clog2(MAX_SOURCES);
   localparam int XW    = (IDX_W > 4) ? IDX_W : 4;
   localparam int CAP   = (MAX_SOURCES < alts_pkg::RESULT_CAP) ? MAX_SOURCES
                                                               : alts_pkg::RESULT_CAP;
   localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(MAX_SOURCES - 1);
   localparam logic [IDX_W:0]   K_END    = (IDX_W + 1)'(MAX_SOURCES);

   localparam logic [2:0] ST_IDLE     = 3'd0;
   localparam logic [2:0] ST_SAMPLE   = 3'd1;
   localparam logic [2:0] ST_SCAN_RD  = 3'd2;
   localparam logic [2:0] ST_SCAN_CHK = 3'd3;
   localparam logic [2:0] ST_SCAN_DIV = 3'd4;
   localparam logic [2:0] ST_SEL_SCAN = 3'd5;
   localparam logic [2:0] ST_SEL_OUT  = 3'd6;
   localparam logic [2:0] ST_SILENCE  = 3'd7;

   logic [2:0]             st_ff, st_in;
   logic [4:0]             max_ff, max_in;
   logic [7:0]             thr_ff, thr_in;
   logic [12:0]            ivl_ff, ivl_in;
   logic [12:0]            ms_ff, ms_in;
   logic                   paused_ff, paused_in;
   logic                   silent_ff, silent_in;
   logic [MAX_SOURCES-1:0] active_ff, active_in;
   logic [MAX_SOURCES-1:0] cand_ff, cand_in;
   logic [IDX_W:0]         cand_cnt_ff, cand_cnt_in;
   logic [IDX_W-1:0]       j_ff, j_in;
   logic [IDX_W:0]         k_ff, k_in;
   logic                   pend_ff, pend_in;
   logic [IDX_W-1:0]       pend_idx_ff, pend_idx_in;
   logic                   have_best_ff, have_best_in;
   logic [IDX_W-1:0]       best_idx_ff, best_idx_in;
   logic [6:0]             best_q_ff, best_q_in;
   logic [4:0]             n_ff, n_in;
   logic [IDX_W-1:0]       slot_ff, slot_in;
   logic [6:0]             level_ff, level_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   alts_pkg::rsp_type      rsp_data_ff, rsp_data_in;

   logic [6:0]             avg_mem [MAX_SOURCES];
   logic [6:0]             avg_rd_ff;
   logic                   avg_rd_en;
   logic                   avg_wr_en;
   logic [6:0]             avg_wr_q;

   alts_pkg::tbl_cmd_type  tbl_cmd;
   logic [IDX_W-1:0]       tbl_addr;
   alts_pkg::stats_type    tbl_wr;
   alts_pkg::stats_type    tbl_rd;

   logic                   div_start;
   logic                   div_done;
   logic [15:0]            div_quo;

   logic                   accept;
   logic                   out_free;
   logic                   slot_ok;
   logic [XW-1:0]          req_x;
   logic [IDX_W-1:0]       req_idx;
   logic [12:0]            ivl_cl;
   logic [12:0]            ms_inc;
   logic [4:0]             limit;
   logic                   last_mark;
   logic [16:0]            sum_ext;
   logic [6:0]             q_cl;
   logic [7:0]             avg8;
   logic                   scan_adv;
   logic [XW-1:0]          best_x;

   alts_table #(
      .MAX_SOURCES(MAX_SOURCES)
   ) u_table (
      .clock   (clock),
      .reset   (reset),
      .cmd     (tbl_cmd),
      .addr    (tbl_addr),
      .wr_data (tbl_wr),
      .rd_data (tbl_rd)
   );

   alts_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (tbl_rd.level_sum),
      .divisor  (tbl_rd.sample_count),
      .done     (div_done),
      .quotient (div_quo)
   );

   assign accept    = req_valid && !req_stall;
   assign req_stall = (st_ff != ST_IDLE);
   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign csr_ready = 1'b1;
   assign req_x     = XW'(req_data.source_slot);
   assign req_idx   = req_x[IDX_W-1:0];
   assign slot_ok   = int'(req_data.source_slot) < MAX_SOURCES;
   assign ivl_cl    = (ivl_ff < alts_pkg::IVL_MIN) ? alts_pkg::IVL_MIN :
                      (ivl_ff > alts_pkg::IVL_MAX) ? alts_pkg::IVL_MAX : ivl_ff;
   assign ms_inc    = ms_ff + 13'd1;
   assign limit     = (max_ff == 5'd0) ? 5'd1 :
                      (max_ff > 5'(CAP)) ? 5'(CAP) : max_ff;
   assign last_mark = ((n_ff + 5'd1) == limit) || (cand_cnt_ff == (IDX_W + 1)'(1));
   assign sum_ext   = {1'b0, tbl_rd.level_sum} + {10'd0, level_ff};
   assign q_cl      = (div_quo > 16'd127) ? 7'd127 : div_quo[6:0];
   assign avg8      = 8'd0 - {1'b0, q_cl};
   assign best_x    = XW'(best_idx_ff);
   assign avg_wr_q  = q_cl;

   always_comb begin
      st_in        = st_ff;
      max_in       = max_ff;
      thr_in       = thr_ff;
      ivl_in       = ivl_ff;
      ms_in        = ms_ff;
      paused_in    = paused_ff;
      silent_in    = silent_ff;
      active_in    = active_ff;
      cand_in      = cand_ff;
      cand_cnt_in  = cand_cnt_ff;
      j_in         = j_ff;
      k_in         = k_ff;
      pend_in      = 1'b0;
      pend_idx_in  = pend_idx_ff;
      have_best_in = have_best_ff;
      best_idx_in  = best_idx_ff;
      best_q_in    = best_q_ff;
      n_in         = n_ff;
      slot_in      = slot_ff;
      level_in     = level_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_data_in  = rsp_data_ff;
      tbl_cmd      = '0;
      tbl_addr     = j_ff;
      tbl_wr       = '0;
      div_start    = 1'b0;
      avg_rd_en    = 1'b0;
      avg_wr_en    = 1'b0;
      scan_adv     = 1'b0;

      if (csr_valid && csr_ready) begin
         case (csr_index)
            alts_pkg::CSR_MAX_ENTRIES: max_in = csr_wdata[4:0];
            alts_pkg::CSR_THRESHOLD:   thr_in = csr_wdata[7:0];
            alts_pkg::CSR_INTERVAL:    ivl_in = csr_wdata;
            default: ;
         endcase
      end

      case (st_ff)
         ST_IDLE: begin
            tbl_addr = req_idx;
            if (accept) begin
               case (req_data.kind)
                  alts_pkg::KIND_SAMPLE: begin
                     if (!paused_ff && slot_ok && active_ff[req_idx]) begin
                        tbl_cmd.rd_en = 1'b1;
                        slot_in       = req_idx;
                        level_in      = req_data.audio_level;
                        st_in         = ST_SAMPLE;
                     end
                  end
                  alts_pkg::KIND_TICK: begin
                     if (!paused_ff) begin
                        if (ms_inc >= ivl_cl) begin
                           ms_in       = '0;
                           j_in        = '0;
                           cand_in     = '0;
                           cand_cnt_in = '0;
                           st_in       = ST_SCAN_RD;
                        end else begin
                           ms_in = ms_inc;
                        end
                     end
                  end
                  alts_pkg::KIND_ATTACH: begin
                     if (slot_ok && !active_ff[req_idx]) begin
                        active_in[req_idx] = 1'b1;
                        tbl_cmd.clr_one    = 1'b1;
                     end
                  end
                  alts_pkg::KIND_DETACH: begin
                     if (slot_ok) begin
                        active_in[req_idx] = 1'b0;
                        tbl_cmd.clr_one    = 1'b1;
                     end
                  end
                  alts_pkg::KIND_PAUSE: begin
                     paused_in       = 1'b1;
                     ms_in           = '0;
                     tbl_cmd.clr_all = 1'b1;
                     if (!silent_ff) begin
                        silent_in = 1'b1;
                        st_in     = ST_SILENCE;
                     end
                  end
                  alts_pkg::KIND_RESUME: begin
                     paused_in = 1'b0;
                     ms_in     = '0;
                  end
                  default: ;
               endcase
            end
         end
         ST_SAMPLE: begin
            tbl_addr              = slot_ff;
            tbl_cmd.wr_en         = 1'b1;
            tbl_wr.level_sum      = sum_ext[16] ? 16'hFFFF : sum_ext[15:0];
            tbl_wr.sample_count   = (tbl_rd.sample_count == 16'hFFFF) ? 16'hFFFF
                                    : tbl_rd.sample_count + 16'd1;
            st_in                 = ST_IDLE;
         end
         ST_SCAN_RD: begin
            tbl_cmd.rd_en = 1'b1;
            st_in         = ST_SCAN_CHK;
         end
         ST_SCAN_CHK: begin
            if (active_ff[j_ff] && (tbl_rd.sample_count >= 16'(MIN_SAMPLES))) begin
               div_start = 1'b1;
               st_in     = ST_SCAN_DIV;
            end else begin
               scan_adv = 1'b1;
            end
         end
         ST_SCAN_DIV: begin
            if (div_done) begin
               avg_wr_en = 1'b1;
               if ($signed(avg8) >= $signed(thr_ff)) begin
                  cand_in[j_ff] = 1'b1;
                  cand_cnt_in   = cand_cnt_ff + (IDX_W + 1)'(1);
               end
               scan_adv = 1'b1;
            end
         end
         ST_SEL_SCAN: begin
            if (k_ff != K_END) begin
               avg_rd_en   = 1'b1;
               pend_in     = 1'b1;
               pend_idx_in = k_ff[IDX_W-1:0];
               k_in        = k_ff + (IDX_W + 1)'(1);
            end else begin
               st_in = ST_SEL_OUT;
            end
            if (pend_ff && cand_ff[pend_idx_ff]) begin
               if (!have_best_ff || (avg_rd_ff < best_q_ff)) begin
                  have_best_in = 1'b1;
                  best_idx_in  = pend_idx_ff;
                  best_q_in    = avg_rd_ff;
               end
            end
         end
         ST_SEL_OUT: begin
            if (out_free) begin
               rsp_valid_in              = 1'b1;
               rsp_data_in.event_res     = alts_pkg::EV_VOLUME;
               rsp_data_in.speaker_slot  = best_x[3:0];
               rsp_data_in.average_dbov  = 8'd0 - {1'b0, best_q_ff};
               rsp_data_in.last_of_run   = last_mark;
               cand_in[best_idx_ff]      = 1'b0;
               cand_cnt_in               = cand_cnt_ff - (IDX_W + 1)'(1);
               n_in                      = n_ff + 5'd1;
               if (last_mark) begin
                  st_in = ST_IDLE;
               end else begin
                  k_in         = '0;
                  have_best_in = 1'b0;
                  st_in        = ST_SEL_SCAN;
               end
            end
         end
         ST_SILENCE: begin
            if (out_free) begin
               rsp_valid_in             = 1'b1;
               rsp_data_in.event_res    = alts_pkg::EV_SILENCE;
               rsp_data_in.speaker_slot = 4'd0;
               rsp_data_in.average_dbov = 8'd0;
               rsp_data_in.last_of_run  = 1'b1;
               st_in                    = ST_IDLE;
            end
         end
         default: st_in = ST_IDLE;
      endcase

      if (scan_adv) begin
         if (j_ff == LAST_IDX) begin
            tbl_cmd.clr_all = 1'b1;
            if (cand_cnt_in != '0) begin
               silent_in    = 1'b0;
               n_in         = '0;
               k_in         = '0;
               have_best_in = 1'b0;
               st_in        = ST_SEL_SCAN;
            end else if (!silent_ff) begin
               silent_in = 1'b1;
               st_in     = ST_SILENCE;
            end else begin
               st_in = ST_IDLE;
            end
         end else begin
            j_in  = j_ff + IDX_W'(1);
            st_in = ST_SCAN_RD;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (avg_wr_en) begin
         avg_mem[j_ff] <= avg_wr_q;
      end
      if (avg_rd_en) begin
         avg_rd_ff <= avg_mem[k_ff[IDX_W-1:0]];
      end
   end

   always_ff @(posedge clock) begin
      j_ff        <= j_in;
      k_ff        <= k_in;
      pend_idx_ff <= pend_idx_in;
      best_idx_ff <= best_idx_in;
      best_q_ff   <= best_q_in;
      n_ff        <= n_in;
      slot_ff     <= slot_in;
      level_ff    <= level_in;
      rsp_data_ff <= rsp_data_in;
      if (reset) begin
         st_ff        <= ST_IDLE;
         max_ff       <= 5'd1;
         thr_ff       <= 8'hB0;
         ivl_ff       <= 13'd1000;
         ms_ff        <= '0;
         paused_ff    <= 1'b0;
         silent_ff    <= 1'b1;
         active_ff    <= '0;
         cand_ff      <= '0;
         cand_cnt_ff  <= '0;
         pend_ff      <= 1'b0;
         have_best_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         st_ff        <= st_in;
         max_ff       <= max_in;
         thr_ff       <= thr_in;
         ivl_ff       <= ivl_in;
         ms_ff        <= ms_in;
         paused_ff    <= paused_in;
         silent_ff    <= silent_in;
         active_ff    <= active_in;
         cand_ff      <= cand_in;
         cand_cnt_ff  <= cand_cnt_in;
         pend_ff      <= pend_in;
         have_best_ff <= have_best_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

// ----- hw/rtl/alts_checker.sv -----
// Port-level checks for the audio level ranking block, bound to its top level.
// Depends on alts_pkg for the beat types.
module alts_checker (
   input logic              clock,
   input logic              reset,
   input logic              req_valid,
   input logic              req_stall,
   input alts_pkg::req_type req_data,
   input logic              rsp_valid,
   input logic              rsp_stall,
   input alts_pkg::rsp_type rsp_data,
   input logic              csr_valid,
   input logic              csr_ready,
   input logic [1:0]        csr_index,
   input logic [12:0]       csr_wdata
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_data))
      else $error("stalled result beat changed");

   a_reset_idle: assert property (@(posedge clock)
      reset |=> !rsp_valid && !req_stall)
      else $error("block not idle after reset");

   a_silence_form: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_data.event_res == alts_pkg::EV_SILENCE) |->
      rsp_data.last_of_run && (rsp_data.speaker_slot == 4'd0) &&
      (rsp_data.average_dbov == 8'sd0))
      else $error("malformed silence beat");

   a_volume_sign: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_data.event_res == alts_pkg::EV_VOLUME) |->
      rsp_data.average_dbov[7] || (rsp_data.average_dbov == 8'sd0))
      else $error("volume beat with positive average");

   a_cfg_ready: assert property (@(posedge clock) disable iff (reset)
      csr_valid |-> csr_ready)
      else $error("configuration write refused");

endmodule

bind audio_level_top_speakers alts_checker u_alts_checker (.*);

// ----- verif/audio_level_top_speakers_tb.sv -----
// Testbench for audio_level_top_speakers: directed and random event streams
// checked beat by beat against a behavioural predictor of the ranking logic.
// Depends on alts_pkg and the RTL of the block only.
`timescale 1ns / 100ps

module audio_level_top_speakers_tb;

   localparam int SLOTS       = 16;
   localparam int ENOUGH      = 10;
   localparam int SETTLE_CYC  = 800;

   logic    clock;
   logic    reset;
   logic    req_valid;
   logic    req_stall;
   alts_pkg::req_type req_data;
   logic    rsp_valid;
   logic    rsp_stall;
   alts_pkg::rsp_type rsp_data;
   logic    csr_valid;
   logic    csr_ready;
   logic [1:0]  csr_index;
   logic [12:0] csr_wdata;

   audio_level_top_speakers dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_data(rsp_data),
      .csr_valid(csr_valid), .csr_ready(csr_ready),
      .csr_index(csr_index), .csr_wdata(csr_wdata)
   );

   // predictor state
   logic        src_active [SLOTS];
   logic [15:0] src_sum    [SLOTS];
   logic [15:0] src_count  [SLOTS];
   logic        is_silent;
   logic        is_paused;
   int unsigned ticks_done;
   logic [4:0]        cfg_entries;
   logic signed [7:0] cfg_threshold;
   logic [12:0]       cfg_interval;

   alts_pkg::rsp_type expected_beats [$];
   int      mismatches;
   bit      idle_en;
   int      stall_left;

   always begin
      clock = 1'b1; #5;
      clock = 1'b0; #5;
   end

   task automatic report_mismatch(input string what, input int got, input int want);
      $display("mismatch %s: got %0d want %0d at %0t", what, got, want, $realtime);
      mismatches++;
   endtask

   function automatic int unsigned live_interval();
      int unsigned iv;
      iv = cfg_interval;
      if (iv < 250) iv = 250;
      if (iv > 5000) iv = 5000;
      return iv;
   endfunction

   function automatic void clear_stats();
      for (int i = 0; i < SLOTS; i++) begin
         src_sum[i] = '0;
         src_count[i] = '0;
      end
   endfunction

   function automatic void push_silence();
      alts_pkg::rsp_type b;
      b = '0;
      b.event_res = alts_pkg::EV_SILENCE;
      b.last_of_run = 1'b1;
      expected_beats.push_back(b);
   endfunction

   function automatic void rank_interval();
      int avg [SLOTS];
      bit cand [SLOTS];
      int lim, n, best, q;
      bit any;
      alts_pkg::rsp_type b;
      any = 0;
      n = 0;
      lim = cfg_entries;
      if (lim < 1) lim = 1;
      if (lim > SLOTS) lim = SLOTS;
      for (int i = 0; i < SLOTS; i++) begin
         cand[i] = 0;
         avg[i] = 0;
         if (src_active[i] && src_count[i] >= ENOUGH) begin
            q = src_sum[i] / src_count[i];
            if (q > 127) q = 127;
            avg[i] = -q;
            if (avg[i] >= cfg_threshold) begin
               cand[i] = 1;
               any = 1;
            end
         end
      end
      clear_stats();
      if (any) begin
         is_silent = 0;
         while (n < lim) begin
            best = -1;
            for (int i = 0; i < SLOTS; i++)
               if (cand[i] && (best < 0 || avg[i] > avg[best])) best = i;
            if (best < 0) break;
            cand[best] = 0;
            b = '0;
            b.event_res = alts_pkg::EV_VOLUME;
            b.speaker_slot = best[3:0];
            b.average_dbov = avg[best][7:0];
            expected_beats.push_back(b);
            n++;
         end
         expected_beats[$].last_of_run = 1'b1;
      end else if (!is_silent) begin
         is_silent = 1;
         push_silence();
      end
   endfunction

   function automatic void predict_event(input alts_pkg::req_type r);
      int s;
      s = r.source_slot;
      case (r.kind)
         alts_pkg::KIND_SAMPLE: begin
            if (!is_paused && src_active[s]) begin
               src_sum[s] = (int'(src_sum[s]) + r.audio_level > 65535) ? 16'hFFFF
                            : src_sum[s] + r.audio_level;
               if (src_count[s] != 16'hFFFF) src_count[s]++;
            end
         end
         alts_pkg::KIND_TICK: begin
            if (!is_paused) begin
               ticks_done++;
               if (ticks_done >= live_interval()) begin
                  ticks_done = 0;
                  rank_interval();
               end
            end
         end
         alts_pkg::KIND_ATTACH: begin
            if (!src_active[s]) begin
               src_active[s] = 1;
               src_sum[s] = '0;
               src_count[s] = '0;
            end
         end
         alts_pkg::KIND_DETACH: begin
            src_active[s] = 0;
            src_sum[s] = '0;
            src_count[s] = '0;
         end
         alts_pkg::KIND_PAUSE: begin
            is_paused = 1;
            ticks_done = 0;
            clear_stats();
            if (!is_silent) begin
               is_silent = 1;
               push_silence();
            end
         end
         alts_pkg::KIND_RESUME: begin
            is_paused = 0;
            ticks_done = 0;
         end
         default: ;
      endcase
   endfunction

   // called at a rising edge; returns at the edge where the beat is taken
   task automatic send_event(input logic [2:0] kind, input int slot, input int level);
      alts_pkg::req_type r;
      r.kind = kind;
      r.source_slot = slot[3:0];
      r.audio_level = level[6:0];
      if (idle_en && $urandom_range(0, 4) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 5)) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data <= r;
      predict_event(r);
      do @(posedge clock); while (req_stall);
   endtask

   task automatic send_ticks(input int n);
      for (int i = 0; i < n; i++) send_event(alts_pkg::KIND_TICK, 0, 0);
   endtask

   task automatic write_csr(input logic [1:0] idx, input logic [12:0] val);
      req_valid <= 1'b0;
      @(posedge clock);
      wait (expected_beats.size() == 0);
      repeat (SETTLE_CYC) @(posedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      case (idx)
         alts_pkg::CSR_MAX_ENTRIES: cfg_entries = val[4:0];
         alts_pkg::CSR_THRESHOLD:   cfg_threshold = val[7:0];
         alts_pkg::CSR_INTERVAL:    cfg_interval = val;
         default: ;
      endcase
   endtask

   task automatic test_defaults();
      send_event(alts_pkg::KIND_ATTACH, 0, 0);
      send_event(alts_pkg::KIND_ATTACH, 15, 0);
      send_event(alts_pkg::KIND_ATTACH, 15, 0);
      send_event(alts_pkg::KIND_SAMPLE, 3, 0);
      send_event(3'd6, 5, 127);
      send_event(3'd7, 10, 85);
      for (int i = 0; i < 10; i++) begin
         send_event(alts_pkg::KIND_SAMPLE, 0, 0);
         send_event(alts_pkg::KIND_SAMPLE, 15, 127);
      end
      send_ticks(live_interval());
   endtask

   task automatic test_ties_and_limit();
      write_csr(alts_pkg::CSR_MAX_ENTRIES, 13'h1F);
      write_csr(alts_pkg::CSR_THRESHOLD, 13'h081);
      write_csr(alts_pkg::CSR_INTERVAL, 13'd0);
      for (int s = 0; s < SLOTS; s++) send_event(alts_pkg::KIND_ATTACH, s, 0);
      for (int k = 0; k < ENOUGH; k++)
         for (int s = 0; s < SLOTS; s++)
            send_event(alts_pkg::KIND_SAMPLE, s, (s < 8) ? 40 : 20 + s);
      send_ticks(live_interval());
      send_ticks(live_interval());
      write_csr(alts_pkg::CSR_MAX_ENTRIES, 13'd0);
      for (int k = 0; k < ENOUGH; k++) send_event(alts_pkg::KIND_SAMPLE, 9, 5);
      send_ticks(live_interval());
   endtask

   task automatic test_saturation_and_threshold();
      write_csr(alts_pkg::CSR_MAX_ENTRIES, 13'd16);
      write_csr(alts_pkg::CSR_THRESHOLD, 13'd0);
      send_event(alts_pkg::KIND_DETACH, 2, 0);
      for (int k = 0; k < 600; k++) send_event(alts_pkg::KIND_SAMPLE, 4, 127);
      for (int k = 0; k < ENOUGH; k++) send_event(alts_pkg::KIND_SAMPLE, 6, 0);
      send_ticks(live_interval());
      write_csr(alts_pkg::CSR_THRESHOLD, 13'd5);
      for (int k = 0; k < ENOUGH; k++) send_event(alts_pkg::KIND_SAMPLE, 6, 0);
      send_ticks(live_interval());
      write_csr(alts_pkg::CSR_THRESHOLD, 13'h081);
   endtask

   task automatic test_pause_resume();
      for (int k = 0; k < ENOUGH; k++) send_event(alts_pkg::KIND_SAMPLE, 1, 12);
      send_ticks(live_interval());
      send_ticks(20);
      send_event(alts_pkg::KIND_PAUSE, 0, 0);
      send_event(alts_pkg::KIND_SAMPLE, 1, 3);
      send_ticks(300);
      send_event(alts_pkg::KIND_PAUSE, 0, 0);
      send_event(alts_pkg::KIND_RESUME, 0, 0);
      send_ticks(100);
      send_event(alts_pkg::KIND_RESUME, 0, 0);
      for (int k = 0; k < ENOUGH; k++) send_event(alts_pkg::KIND_SAMPLE, 1, 12);
      send_ticks(live_interval());
   endtask

   task automatic random_round();
      int pick, lvl;
      for (int i = 0; i < 70; i++) begin
         pick = $urandom_range(0, 99);
         lvl = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 127) : $urandom_range(0, 50);
         if (pick < 78)
            send_event(alts_pkg::KIND_SAMPLE, $urandom_range(0, 15), lvl);
         else if (pick < 86)
            send_event(alts_pkg::KIND_ATTACH, $urandom_range(0, 15), lvl);
         else if (pick < 91)
            send_event(alts_pkg::KIND_DETACH, $urandom_range(0, 15), lvl);
         else if (pick < 93)
            send_event(alts_pkg::KIND_PAUSE, $urandom_range(0, 15), lvl);
         else if (pick < 96)
            send_event(alts_pkg::KIND_RESUME, $urandom_range(0, 15), lvl);
         else
            send_event(alts_pkg::KIND_TICK, $urandom_range(0, 15), lvl);
      end
      if (is_paused) send_event(alts_pkg::KIND_RESUME, 0, 0);
      send_ticks(live_interval() - ticks_done);
   endtask

   task automatic test_random();
      logic [12:0] ents [4] = '{13'd1, 13'd16, 13'd5, 13'd3};
      logic [12:0] thrs [4] = '{13'h0B0, 13'h081, 13'h0D8, 13'h000};
      logic [12:0] ivls [4] = '{13'd0, 13'd250, 13'h1FFF, 13'd251};
      int rounds;
      for (int p = 0; p < 4; p++) begin
         write_csr(alts_pkg::CSR_MAX_ENTRIES, ents[p]);
         write_csr(alts_pkg::CSR_THRESHOLD, thrs[p]);
         write_csr(alts_pkg::CSR_INTERVAL, ivls[p]);
         if (p == 3) idle_en = 0;
         rounds = (live_interval() > 1000) ? 1 : 2;
         for (int k = 0; k < rounds; k++) random_round();
      end
   endtask

   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_beats.size() == 0) begin
            report_mismatch("unexpected beat, slot", rsp_data.speaker_slot, -1);
         end else begin
            alts_pkg::rsp_type w;
            w = expected_beats.pop_front();
            if (rsp_data.event_res !== w.event_res)
               report_mismatch("event_res", rsp_data.event_res, w.event_res);
            if (rsp_data.speaker_slot !== w.speaker_slot)
               report_mismatch("speaker_slot", rsp_data.speaker_slot, w.speaker_slot);
            if (rsp_data.average_dbov !== w.average_dbov)
               report_mismatch("average_dbov", rsp_data.average_dbov, w.average_dbov);
            if (rsp_data.last_of_run !== w.last_of_run)
               report_mismatch("last_of_run", rsp_data.last_of_run, w.last_of_run);
         end
      end
   end

   always @(posedge clock) begin
      if (stall_left > 0) begin
         stall_left <= stall_left - 1;
         rsp_stall <= 1'b1;
      end else if (idle_en && $urandom_range(0, 5) == 0) begin
         stall_left <= $urandom_range(0, 4);
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= 1'b0;
      end
   end

   initial begin
      #5_000_000;
      $display("TEST FAILED");
      $finish;
   end

   initial begin
      reset = 1'b1;
      req_valid = 1'b0;
      req_data = '0;
      rsp_stall = 1'b0;
      csr_valid = 1'b0;
      csr_index = '0;
      csr_wdata = '0;
      stall_left = 0;
      mismatches = 0;
      idle_en = 1;
      for (int i = 0; i < SLOTS; i++) src_active[i] = 0;
      clear_stats();
      is_silent = 1;
      is_paused = 0;
      ticks_done = 0;
      cfg_entries = 5'd1;
      cfg_threshold = -8'sd80;
      cfg_interval = 13'd1000;
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_defaults();
      test_ties_and_limit();
      test_saturation_and_threshold();
      test_pause_resume();
      test_random();
      req_valid <= 1'b0;
      wait (expected_beats.size() == 0);
      repeat (SETTLE_CYC) @(posedge clock);
      if (mismatches == 0 && expected_beats.size() == 0)
         $display("TEST PASSED");
      else
         $display("TEST FAILED");
      $finish;
   end

endmodule
